/* hw/rtl/mrc_pkg.sv */
// shared types, codes and constant tables for the meter range converter
`timescale 1ns / 1ps

package mrc_pkg;

	// field widths
	localparam int ACTION_W  = 2;
	localparam int RANGE_W   = 8;
	localparam int ADC_W     = 12;
	localparam int READING_W = 20;
	localparam int UNIT_W    = 3;
	localparam int DEC_W     = 2;
	localparam int MUX_W     = 14;
	localparam int SCALE_W   = 14;
	localparam int PROD_W    = 26;
	localparam int CAP_IDX_W = 3;
	localparam int CAP_NUM_MAX = 235;

	// apb
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_MUX_RES = 1'b0;

	localparam logic [READING_W-1:0] READ_MAX = '1;

	// actions
	localparam logic [ACTION_W-1:0] ACT_CONVERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_START   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd2;

	// range codes
	localparam logic [RANGE_W-1:0] RNG_OHM       = 8'd0;
	localparam logic [RANGE_W-1:0] RNG_KOHM      = 8'd1;
	localparam logic [RANGE_W-1:0] RNG_KOHM_LO   = 8'd2;
	localparam logic [RANGE_W-1:0] RNG_KOHM_HI   = 8'd3;
	localparam logic [RANGE_W-1:0] RNG_MEG_LO    = 8'd4;
	localparam logic [RANGE_W-1:0] RNG_MEG_HI    = 8'd5;
	localparam logic [RANGE_W-1:0] RNG_CAP_FIRST = 8'd10;
	localparam logic [RANGE_W-1:0] RNG_CAP_LAST  = 8'd17;
	localparam logic [RANGE_W-1:0] RNG_DIODE     = 8'd20;
	localparam logic [RANGE_W-1:0] RNG_RAW       = 8'd50;

	// units
	localparam logic [UNIT_W-1:0] UNIT_OHM  = 3'd0;
	localparam logic [UNIT_W-1:0] UNIT_KOHM = 3'd1;
	localparam logic [UNIT_W-1:0] UNIT_MEG  = 3'd2;
	localparam logic [UNIT_W-1:0] UNIT_VOLT = 3'd3;
	localparam logic [UNIT_W-1:0] UNIT_NF   = 3'd4;
	localparam logic [UNIT_W-1:0] UNIT_UF   = 3'd5;
	localparam logic [UNIT_W-1:0] UNIT_RAW  = 3'd6;

	localparam logic [DEC_W-1:0] DEC_0 = 2'd0;
	localparam logic [DEC_W-1:0] DEC_1 = 2'd1;
	localparam logic [DEC_W-1:0] DEC_2 = 2'd2;

	// capacitance range index (range minus 10)
	localparam logic [CAP_IDX_W-1:0] CAP_TIME = 3'd0;
	localparam logic [CAP_IDX_W-1:0] CAP_NF0  = 3'd1;
	localparam logic [CAP_IDX_W-1:0] CAP_NF1  = 3'd2;
	localparam logic [CAP_IDX_W-1:0] CAP_NF2  = 3'd3;
	localparam logic [CAP_IDX_W-1:0] CAP_NF3  = 3'd4;
	localparam logic [CAP_IDX_W-1:0] CAP_NF4  = 3'd5;
	localparam logic [CAP_IDX_W-1:0] CAP_UF0  = 3'd6;
	localparam logic [CAP_IDX_W-1:0] CAP_UF1  = 3'd7;

	// reciprocals scaled by 2^32, rounded up
	localparam logic [32:0] MAGIC_ONE = 33'h1_0000_0000;
	localparam logic [32:0] MAGIC_5   = 33'((64'h1_0000_0000 + 64'd4) / 64'd5);
	localparam logic [32:0] MAGIC_11  = 33'((64'h1_0000_0000 + 64'd10) / 64'd11);
	localparam logic [32:0] MAGIC_63  = 33'((64'h1_0000_0000 + 64'd62) / 64'd63);
	localparam logic [32:0] MAGIC_103 = 33'((64'h1_0000_0000 + 64'd102) / 64'd103);

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [RANGE_W-1:0]  range;
		logic [ADC_W-1:0]    adc_code;
		logic                sense_high;
	} in_item_t;

	typedef struct packed {
		logic [READING_W-1:0] reading;
		logic [UNIT_W-1:0]    unit;
		logic [DEC_W-1:0]     decimals;
		logic                 short_flag;
	} out_item_t;

	typedef struct packed {
		logic      known;
		out_item_t item;
	} conv_res_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} tmr_res_t;

	// front-end scale factor applied to the adc code
	function automatic logic [SCALE_W-1:0] adc_scale(input logic [RANGE_W-1:0] rng);
		logic [SCALE_W-1:0] k;
		unique case (rng)
			RNG_OHM:     k = 14'd3125;
			RNG_KOHM:    k = 14'd15625;
			RNG_KOHM_LO: k = 14'd250;
			RNG_KOHM_HI: k = 14'd2500;
			RNG_MEG_LO:  k = 14'd25;
			RNG_MEG_HI:  k = 14'd625;
			RNG_DIODE:   k = 14'd250;
			default:     k = '0;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] cap_num(input logic [CAP_IDX_W-1:0] k);
		logic [7:0] v;
		unique case (k)
			CAP_NF2: v = 8'd5;
			CAP_NF3: v = 8'd25;
			CAP_NF4: v = 8'd235;
			CAP_UF1: v = 8'd5;
			default: v = 8'd1;
		endcase
		return v;
	endfunction

	function automatic logic [2:0] cap_shift(input logic [CAP_IDX_W-1:0] k);
		logic [2:0] v;
		unique case (k)
			CAP_TIME: v = 3'd2;
			CAP_NF0:  v = 3'd6;
			CAP_NF1:  v = 3'd3;
			CAP_NF2:  v = 3'd3;
			CAP_NF3:  v = 3'd2;
			CAP_NF4:  v = 3'd6;
			CAP_UF0:  v = 3'd2;
			default:  v = 3'd1;
		endcase
		return v;
	endfunction

	function automatic logic [32:0] cap_magic(input logic [CAP_IDX_W-1:0] k);
		logic [32:0] v;
		unique case (k)
			CAP_NF1: v = MAGIC_5;
			CAP_NF2: v = MAGIC_11;
			CAP_NF3: v = MAGIC_11;
			CAP_UF0: v = MAGIC_63;
			CAP_UF1: v = MAGIC_103;
			default: v = MAGIC_ONE;
		endcase
		return v;
	endfunction

	function automatic logic [14:0] cap_zero(input logic [CAP_IDX_W-1:0] k);
		logic [14:0] v;
		unique case (k)
			CAP_NF0: v = 15'd32;
			CAP_NF1: v = 15'd200;
			CAP_NF2: v = 15'd880;
			CAP_NF3: v = 15'd4400;
			CAP_NF4: v = 15'd32000;
			CAP_UF0: v = 15'd252;
			CAP_UF1: v = 15'd2060;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* hw/rtl/mrc_apb_regs.sv */
// apb register block holding the mux resistance
`timescale 1ns / 1ps

module mrc_apb_regs import mrc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [MUX_W-1:0]      mux_res
);

	logic             sel_mux;
	logic [MUX_W-1:0] mux_q;

	assign sel_mux = (paddr[APB_ADDR_W-1] == REG_MUX_RES);
	assign pready  = 1'b1;
	assign prdata  = sel_mux ? APB_DATA_W'(mux_q) : '0;
	assign mux_res = mux_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mux_q <= '0;
		end else if (psel && penable && pwrite && pready && sel_mux) begin
			mux_q <= pwdata[MUX_W-1:0];
		end
	end

endmodule

/* hw/rtl/mrc_adc_convert.sv */
// adc code to reading conversion for resistance, diode and raw ranges
`timescale 1ns / 1ps

module mrc_adc_convert import mrc_pkg::*; (
	input  in_item_t           item,
	input  logic [PROD_W-1:0]  prod,
	input  logic [MUX_W-1:0]   mux_res,
	output conv_res_t          res
);

	localparam logic [18:0] KOHM_MAGIC = 19'(((1 << 28) + 999) / 1000);
	localparam logic [11:0] MEG_MAGIC  = 12'(((1 << 14) + 6) / 7);

	logic signed [PROD_W+1:0] w_ohm;
	logic signed [PROD_W+1:0] w_kohm;
	logic signed [PROD_W+1:0] w_diode;
	logic [36:0]              kohm_prod;
	logic [22:0]              meg_prod;
	logic [ADC_W-1:0]         c;

	assign c = item.adc_code;

	// prod already holds the code times the range scale
	assign w_ohm   = $signed({2'b00, prod}) - $signed((PROD_W+2)'({mux_res, 9'b0}));
	assign w_kohm  = $signed({2'b00, prod}) - $signed((PROD_W+2)'({mux_res, 8'b0}));
	assign w_diode = $signed({2'b00, prod}) - $signed((PROD_W+2)'(20480));

	// divide by 1000 and by 7 through reciprocals
	assign kohm_prod = 37'(w_kohm[25:8]) * 37'(KOHM_MAGIC);
	assign meg_prod  = 23'(prod[21:11]) * 23'(MEG_MAGIC);

	always_comb begin
		res.known           = 1'b1;
		res.item.reading    = '0;
		res.item.unit       = UNIT_RAW;
		res.item.decimals   = DEC_0;
		res.item.short_flag = 1'b0;
		unique case (item.range)
			RNG_OHM: begin
				res.item.unit     = UNIT_OHM;
				res.item.decimals = DEC_2;
				if (w_ohm <= 0) begin
					res.item.reading = '0;
				end else if (w_ohm >= (PROD_W+2)'(20000 * 512)) begin
					res.item.reading = 20'd20000;
				end else begin
					res.item.reading = 20'(w_ohm[23:9]);
				end
			end
			RNG_KOHM: begin
				res.item.unit     = UNIT_KOHM;
				res.item.decimals = DEC_2;
				if (w_kohm >= (PROD_W+2)'(245000 * 256)) begin
					res.item.reading = 20'd250;
				end else if (w_kohm <= (PROD_W+2)'(2560000)) begin
					res.item.reading = '0;
				end else begin
					res.item.reading = 20'(kohm_prod[35:28]);
				end
			end
			RNG_KOHM_LO: begin
				res.item.unit     = UNIT_KOHM;
				res.item.decimals = DEC_1;
				if (c >= 12'd4080) begin
					res.item.reading = 20'd250;
				end else if (c <= 12'd163) begin
					res.item.reading = '0;
				end else begin
					res.item.reading = 20'(prod[PROD_W-1:12]);
				end
			end
			RNG_KOHM_HI: begin
				res.item.unit     = UNIT_KOHM;
				res.item.decimals = DEC_1;
				if (c >= 12'd4080) begin
					res.item.reading = 20'd2500;
				end else if (c <= 12'd65) begin
					res.item.reading = '0;
				end else begin
					res.item.reading = 20'(prod[PROD_W-1:12]);
				end
			end
			RNG_MEG_LO: begin
				res.item.unit     = UNIT_MEG;
				res.item.decimals = DEC_1;
				if (c >= 12'd4080) begin
					res.item.reading = 20'd25;
				end else if (c <= 12'd163) begin
					res.item.reading = '0;
				end else begin
					res.item.reading = 20'(prod[PROD_W-1:12]);
				end
			end
			RNG_MEG_HI: begin
				res.item.unit     = UNIT_MEG;
				res.item.decimals = DEC_1;
				if (c >= 12'd3418) begin
					res.item.reading = 20'd150;
				end else if (c <= 12'd229) begin
					res.item.reading = '0;
				end else begin
					res.item.reading = 20'(meg_prod[22:14]);
				end
			end
			RNG_DIODE: begin
				res.item.unit     = UNIT_VOLT;
				res.item.decimals = DEC_2;
				if (w_diode <= 0) begin
					res.item.reading = '0;
				end else if (w_diode >= (PROD_W+2)'(245 * 4096)) begin
					res.item.reading = 20'd245;
				end else begin
					res.item.reading = 20'(w_diode[19:12]);
				end
			end
			RNG_RAW: begin
				res.item.reading = 20'(c);
			end
			default: begin
				// caller repeats the last reading
				res.known = 1'b0;
			end
		endcase
	end

endmodule

/* hw/rtl/mrc_cap_timer.sv */
// charge timer and capacitance conversion
`timescale 1ns / 1ps

module mrc_cap_timer import mrc_pkg::*; #(
	parameter int TICK_LIMIT = 150000
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  in_item_t item,
	output tmr_res_t res,
	output logic     active
);

	localparam int CNT_W = $clog2(TICK_LIMIT + 1);
	localparam int NUM_W = $clog2(TICK_LIMIT * CAP_NUM_MAX + 1);

	logic                 active_q;
	logic [CNT_W-1:0]     ticks_q;
	logic [NUM_W-1:0]     num_q;
	logic [CAP_IDX_W-1:0] held_q;

	logic                 is_tick;
	logic                 is_start;
	logic                 at_limit;
	logic                 is_uf;
	logic [NUM_W-1:0]     num_sh;
	logic [NUM_W+32:0]    quot_prod;
	logic [NUM_W-1:0]     quot;
	logic [NUM_W+3:0]     scaled;

	assign is_tick  = (item.action == ACT_TICK);
	assign is_start = (item.action == ACT_START) && (item.range >= RNG_CAP_FIRST)
		&& (item.range <= RNG_CAP_LAST);
	assign at_limit = (ticks_q >= CNT_W'(TICK_LIMIT - 1));
	assign is_uf    = (held_q == CAP_UF0) || (held_q == CAP_UF1);
	assign active   = active_q;

	// num_q tracks ticks times the range numerator
	assign num_sh    = num_q >> cap_shift(held_q);
	assign quot_prod = (NUM_W+33)'(num_sh) * (NUM_W+33)'(cap_magic(held_q));
	assign quot      = quot_prod[NUM_W+31:32];
	assign scaled    = is_uf ? ((NUM_W+4)'({quot, 3'b0}) + (NUM_W+4)'({quot, 1'b0}))
		: (NUM_W+4)'(quot);

	always_comb begin
		res.valid           = is_tick && active_q && (!item.sense_high || at_limit);
		res.item.short_flag = item.sense_high;
		res.item.unit       = UNIT_NF;
		res.item.decimals   = DEC_0;
		if (held_q == CAP_TIME) begin
			res.item.unit = UNIT_RAW;
		end else if (is_uf) begin
			res.item.unit     = UNIT_UF;
			res.item.decimals = DEC_1;
		end
		if (item.sense_high || (num_q <= NUM_W'(cap_zero(held_q)))) begin
			res.item.reading = '0;
		end else if (scaled > (NUM_W+4)'(READ_MAX)) begin
			res.item.reading = READ_MAX;
		end else begin
			res.item.reading = scaled[READING_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ticks_q  <= '0;
			num_q    <= '0;
			held_q   <= CAP_TIME;
		end else if (fire) begin
			if (is_start) begin
				active_q <= 1'b1;
				ticks_q  <= '0;
				num_q    <= '0;
				held_q   <= CAP_IDX_W'(item.range - RNG_CAP_FIRST);
			end else if (is_tick && active_q) begin
				if (!item.sense_high || at_limit) begin
					active_q <= 1'b0;
				end else begin
					ticks_q <= ticks_q + 1'b1;
					num_q   <= num_q + NUM_W'(cap_num(held_q));
				end
			end
		end
	end

endmodule

/* hw/rtl/meter_range_converter_unit.sv */
// top level of the meter range converter
`timescale 1ns / 1ps

// Takes one item per clock while not stalled, into the input register; the input
// register also stores the adc code already multiplied by the range scale factor, and
// the conversion, the charge-timer update and the reading selection sit between that
// register and the result register. The result register lets a new item enter while a
// finished result waits under out_stall; the input stalls only when the item in the input
// register has a result and the result register is full and stalled. Convert items always
// give a result (unknown ranges repeat the last reading), start items never do, and tick
// items give one only when the comparator drops or the tick count reaches TICK_LIMIT. The
// mux resistance register is written over apb and takes effect on the next convert.
module meter_range_converter_unit import mrc_pkg::*; #(
	parameter int TICK_LIMIT = 150000
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [MUX_W-1:0]  mux_res;
	logic [PROD_W-1:0] prod_in;

	logic              valid_s1;
	in_item_t          item_s1;
	logic [PROD_W-1:0] prod_s1;

	conv_res_t         conv;
	tmr_res_t          tmr;
	logic              tmr_active;

	logic              is_convert;
	logic              has_res;
	logic              fire_s1;
	out_item_t         new_item;

	logic              out_valid_q;
	out_item_t         out_q;

	mrc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mux_res (mux_res)
	);

	// scale the code on the way into the input register
	assign prod_in = PROD_W'(in_data.adc_code) * PROD_W'(adc_scale(in_data.range));

	mrc_adc_convert u_conv (
		.item    (item_s1),
		.prod    (prod_s1),
		.mux_res (mux_res),
		.res     (conv)
	);

	mrc_cap_timer #(
		.TICK_LIMIT (TICK_LIMIT)
	) u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.item   (item_s1),
		.res    (tmr),
		.active (tmr_active)
	);

	assign is_convert = (item_s1.action == ACT_CONVERT);
	assign has_res    = is_convert || tmr.valid;
	assign fire_s1    = valid_s1 && (!has_res || !out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && !fire_s1;

	// out_q doubles as the last reading
	always_comb begin
		if (is_convert) begin
			new_item = conv.known ? conv.item : out_q;
		end else begin
			new_item = tmr.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
			prod_s1 <= prod_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (fire_s1 && has_res) begin
			out_valid_q <= 1'b1;
			out_q       <= new_item;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_short_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.short_flag) |-> (out_data.reading == '0))
		else $error("short result with a nonzero reading");

	a_start_arms_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (in_data.action == ACT_START)
			&& (in_data.range >= RNG_CAP_FIRST) && (in_data.range <= RNG_CAP_LAST))
		|-> ##2 tmr_active)
		else $error("charge timer not armed after a start transaction");

	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result appeared without an item in the input register");

endmodule

/* dv/meter_range_converter_unit_test.sv */
// self-checking testbench for the meter range converter with a built-in reading predictor
`timescale 1ns / 1ps

module meter_range_converter_unit_test;
	import mrc_pkg::*;

	localparam int CHARGE_TICK_LIMIT = 150000;
	localparam int LONG_CHARGE_TICKS = 415;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 6;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [RANGE_W-1:0] RNG_REPEAT = 8'd6;
	localparam logic [RANGE_W-1:0] RNG_UNKNOWN = 8'd255;
	localparam logic [APB_ADDR_W-1:0] MUX_ADDR = APB_ADDR_W'(4 * REG_MUX_RES);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	meter_range_converter_unit #(.TICK_LIMIT(CHARGE_TICK_LIMIT)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [MUX_W-1:0] mux_centiohm = '0;
	bit timer_on = 1'b0;
	int unsigned tick_count = 0;
	logic [RANGE_W-1:0] timer_range = '0;
	out_item_t last_result = '0;

	in_item_t stim_q[$];
	out_item_t readings_due[$];
	int pushed = 0;
	int accepted = 0;
	int mismatches = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	bit hold_for_drain = 1'b0;
	int cycles = 0;

	function automatic out_item_t store_reading(longint r, logic [UNIT_W-1:0] u,
			logic [DEC_W-1:0] d, logic s);
		out_item_t o;
		o.reading = (r > longint'(READ_MAX)) ? READ_MAX : READING_W'(r);
		o.unit = u;
		o.decimals = d;
		o.short_flag = s;
		last_result = o;
		return o;
	endfunction

	function automatic out_item_t convert_adc(logic [RANGE_W-1:0] rng, logic [ADC_W-1:0] code);
		longint c, m, x;
		c = code;
		m = mux_centiohm;
		case (rng)
			RNG_OHM: begin
				x = c * 25000 - m * 4096;
				if (x >= longint'(20000) * 4096) return store_reading(20000, UNIT_OHM, DEC_2, 1'b0);
				if (x <= 0) return store_reading(0, UNIT_OHM, DEC_2, 1'b0);
				return store_reading(x / 4096, UNIT_OHM, DEC_2, 1'b0);
			end
			RNG_KOHM: begin
				x = c * 250000 - m * 4096;
				if (x >= longint'(245000) * 4096) return store_reading(250, UNIT_KOHM, DEC_2, 1'b0);
				if (x <= longint'(10000) * 4096) return store_reading(0, UNIT_KOHM, DEC_2, 1'b0);
				return store_reading(x / 4096000, UNIT_KOHM, DEC_2, 1'b0);
			end
			RNG_KOHM_LO: begin
				x = c * 25000;
				if (x >= longint'(24900) * 4096) return store_reading(250, UNIT_KOHM, DEC_1, 1'b0);
				if (x <= longint'(1000) * 4096) return store_reading(0, UNIT_KOHM, DEC_1, 1'b0);
				return store_reading(c * 250 / 4096, UNIT_KOHM, DEC_1, 1'b0);
			end
			RNG_KOHM_HI: begin
				x = c * 250000;
				if (x >= longint'(249000) * 4096) return store_reading(2500, UNIT_KOHM, DEC_1, 1'b0);
				if (x <= longint'(4000) * 4096) return store_reading(0, UNIT_KOHM, DEC_1, 1'b0);
				return store_reading(c * 2500 / 4096, UNIT_KOHM, DEC_1, 1'b0);
			end
			RNG_MEG_LO: begin
				x = c * 2500000;
				if (x >= longint'(2490000) * 4096) return store_reading(25, UNIT_MEG, DEC_1, 1'b0);
				if (x <= longint'(100000) * 4096) return store_reading(0, UNIT_MEG, DEC_1, 1'b0);
				return store_reading(c * 25 / 4096, UNIT_MEG, DEC_1, 1'b0);
			end
			RNG_MEG_HI: begin
				x = c * 250000000;
				if (x >= longint'(14900000) * 57344) return store_reading(150, UNIT_MEG, DEC_1, 1'b0);
				if (x <= longint'(1000000) * 57344) return store_reading(0, UNIT_MEG, DEC_1, 1'b0);
				return store_reading(c * 2500 / 57344, UNIT_MEG, DEC_1, 1'b0);
			end
			RNG_DIODE: begin
				x = c * 250 - 20480;
				if (x >= longint'(245) * 4096) return store_reading(245, UNIT_VOLT, DEC_2, 1'b0);
				if (x <= 0) return store_reading(0, UNIT_VOLT, DEC_2, 1'b0);
				return store_reading(x / 4096, UNIT_VOLT, DEC_2, 1'b0);
			end
			RNG_RAW: return store_reading(c, UNIT_RAW, DEC_0, 1'b0);
			default: return last_result;
		endcase
	endfunction

	function automatic out_item_t charge_reading(logic [RANGE_W-1:0] rng, longint n, bit shorted);
		longint r, num, den, zero;
		logic [UNIT_W-1:0] u;
		logic [DEC_W-1:0] d;
		logic [CAP_IDX_W-1:0] idx;
		u = UNIT_RAW;
		d = DEC_0;
		idx = CAP_IDX_W'(rng - RNG_CAP_FIRST);
		if (idx == CAP_TIME) begin
			r = n / 4;
		end else begin
			case (idx)
				CAP_NF0: begin num = 1; den = 64; zero = 32; end
				CAP_NF1: begin num = 1; den = 40; zero = 200; end
				CAP_NF2: begin num = 5; den = 88; zero = 880; end
				CAP_NF3: begin num = 25; den = 44; zero = 4400; end
				CAP_NF4: begin num = 235; den = 64; zero = 32000; end
				CAP_UF0: begin num = 1; den = 252; zero = 252; end
				default: begin num = 5; den = 206; zero = 2060; end
			endcase
			r = (n * num <= zero) ? 0 : n * num / den;
			if (idx == CAP_UF0 || idx == CAP_UF1) begin
				u = UNIT_UF;
				d = DEC_1;
				r = r * 10;
			end else begin
				u = UNIT_NF;
			end
		end
		return store_reading(shorted ? 0 : r, u, d, shorted);
	endfunction

	// returns 1 when the transaction produces a reading
	function automatic bit meter_step(in_item_t it, output out_item_t res);
		case (it.action)
			ACT_CONVERT: begin
				res = convert_adc(it.range, it.adc_code);
				return 1'b1;
			end
			ACT_START: begin
				if (it.range >= RNG_CAP_FIRST && it.range <= RNG_CAP_LAST) begin
					timer_on = 1'b1;
					tick_count = 0;
					timer_range = it.range;
				end
				return 1'b0;
			end
			ACT_TICK: begin
				if (!timer_on) return 1'b0;
				if (it.sense_high) begin
					tick_count++;
					if (tick_count >= CHARGE_TICK_LIMIT) begin
						timer_on = 1'b0;
						res = charge_reading(timer_range, tick_count, 1'b1);
						return 1'b1;
					end
					return 1'b0;
				end
				timer_on = 1'b0;
				res = charge_reading(timer_range, tick_count, 1'b0);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic flag_error(string why);
		mismatches++;
		if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, why);
	endtask

	always @(posedge clk) begin : driver
		out_item_t res;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				accepted++;
				if (meter_step(in_data, res)) readings_due.push_back(res);
				if (accepted % 211 == 100) hold_for_drain = 1'b1;
			end
			if (hold_for_drain && readings_due.size() == 0) hold_for_drain = 1'b0;
			if (!in_valid || !in_stall) begin
				if (stim_q.size() != 0 && !hold_for_drain
						&& $urandom_range(99) >= send_gap_pct) begin
					in_data <= stim_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		out_item_t want;
		if (arst_n) begin
			if (out_valid === 1'b1 && !out_stall) begin
				if (readings_due.size() == 0) begin
					flag_error($sformatf("unexpected reading %0d unit %0d", out_data.reading,
						out_data.unit));
				end else begin
					want = readings_due.pop_front();
					if (out_data.reading !== want.reading || out_data.unit !== want.unit
							|| out_data.decimals !== want.decimals
							|| out_data.short_flag !== want.short_flag)
						flag_error($sformatf({"expected reading %0d unit %0d dec %0d short %0b, ",
							"got reading %0d unit %0d dec %0d short %0b"},
							want.reading, want.unit, want.decimals, want.short_flag,
							out_data.reading, out_data.unit, out_data.decimals,
							out_data.short_flag));
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL meter_range_converter_unit");
			$finish;
		end
	end

	task automatic push_item(logic [ACTION_W-1:0] a, logic [RANGE_W-1:0] r,
			logic [ADC_W-1:0] c, logic s);
		in_item_t it;
		it.action = a;
		it.range = r;
		it.adc_code = c;
		it.sense_high = s;
		stim_q.push_back(it);
		pushed++;
	endtask

	task automatic write_mux(logic [MUX_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MUX_ADDR;
		pwdata <= {18'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		mux_centiohm = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// wait for every transaction to be taken and every reading to arrive
	task automatic settle();
		while (accepted != pushed || readings_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [RANGE_W-1:0] pick_range();
		case ($urandom_range(7))
			0: return RNG_OHM;
			1: return RNG_KOHM;
			2: return RNG_KOHM_LO;
			3: return RNG_KOHM_HI;
			4: return RNG_MEG_LO;
			5: return RNG_MEG_HI;
			6: return RNG_DIODE;
			default: return RNG_RAW;
		endcase
	endfunction

	task automatic random_convert();
		logic [ADC_W-1:0] code;
		case ($urandom_range(3))
			0: code = 12'($urandom_range(15));
			1: code = 12'(4095 - $urandom_range(15));
			default: code = 12'($urandom_range(4095));
		endcase
		push_item(ACT_CONVERT, ($urandom_range(9) < 8) ? pick_range() : 8'($urandom), code,
			1'($urandom));
	endtask

	task automatic tick_high();
		push_item(ACT_TICK, 8'($urandom), 12'($urandom), 1'b1);
	endtask

	task automatic charge_sequence();
		logic [RANGE_W-1:0] rng;
		int n, span, i;
		rng = RNG_CAP_FIRST + 8'($urandom_range(7));
		// start on a non-capacitance range is dropped by the block
		if ($urandom_range(19) == 0) push_item(ACT_START, pick_range(), 12'($urandom), 1'($urandom));
		push_item(ACT_START, rng, 12'($urandom), 1'($urandom));
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(5)) tick_high();
			push_item(ACT_START, RNG_CAP_FIRST + 8'($urandom_range(7)), 12'($urandom),
				1'($urandom));
		end
		span = $urandom_range(19);
		n = (span < 14) ? $urandom_range(12) : (span < 19) ? $urandom_range(60)
			: $urandom_range(200);
		for (i = 0; i < n; i++) begin
			case ($urandom_range(99))
				0, 1: random_convert();
				2: push_item(ACT_UNUSED, 8'($urandom), 12'($urandom), 1'($urandom));
				default: ;
			endcase
			tick_high();
		end
		// now and then the measurement is left open
		if ($urandom_range(9) != 0) push_item(ACT_TICK, 8'($urandom), 12'($urandom), 1'b0);
	endtask

	task automatic random_chunk(int budget, int min_charges);
		int start, charges, sel;
		start = pushed;
		charges = 0;
		while ((pushed - start) < budget || charges < min_charges) begin
			sel = $urandom_range(99);
			if (sel < 40) begin
				random_convert();
			end else if (sel < 80) begin
				charges++;
				charge_sequence();
			end else begin
				push_item(2'($urandom), 8'($urandom), 12'($urandom), 1'($urandom));
			end
		end
	endtask

	initial begin : sequencer
		logic [MUX_W-1:0] mux_plan[6];
		int k;
		mux_plan[0] = 14'd10000;
		mux_plan[1] = '1;
		mux_plan[2] = 14'($urandom_range(10000));
		mux_plan[3] = 14'd1;
		mux_plan[4] = 14'($urandom);
		mux_plan[5] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 25;
		recv_stall_pct = 53;
		write_mux('0);
		push_item(ACT_CONVERT, RNG_OHM, 12'd0, 1'b0);
		push_item(ACT_CONVERT, RNG_OHM, 12'd4095, 1'b1);
		push_item(ACT_CONVERT, RNG_KOHM, 12'd4095, 1'b0);
		push_item(ACT_CONVERT, RNG_KOHM, 12'd2000, 1'b0);
		push_item(ACT_CONVERT, RNG_KOHM_LO, 12'd4095, 1'b0);
		push_item(ACT_CONVERT, RNG_KOHM_HI, 12'd2048, 1'b0);
		push_item(ACT_CONVERT, RNG_MEG_LO, 12'd2000, 1'b0);
		push_item(ACT_CONVERT, RNG_MEG_HI, 12'd4095, 1'b0);
		push_item(ACT_CONVERT, RNG_DIODE, 12'd0, 1'b0);
		push_item(ACT_CONVERT, RNG_DIODE, 12'd4095, 1'b0);
		push_item(ACT_CONVERT, RNG_RAW, 12'd4095, 1'b0);
		push_item(ACT_CONVERT, RNG_REPEAT, 12'd100, 1'b0);
		push_item(ACT_CONVERT, RNG_UNKNOWN, 12'd100, 1'b0);
		push_item(ACT_CONVERT, RNG_CAP_FIRST + 8'd2, 12'd100, 1'b0);
		push_item(ACT_UNUSED, RNG_RAW, 12'd4095, 1'b1);
		push_item(ACT_TICK, RNG_CAP_FIRST, 12'd0, 1'b0);
		push_item(ACT_START, RNG_CAP_FIRST - 8'd1, 12'd0, 1'b0);
		push_item(ACT_START, RNG_CAP_FIRST + 8'd1, 12'd0, 1'b0);
		push_item(ACT_TICK, RNG_OHM, 12'd0, 1'b1);
		push_item(ACT_TICK, RNG_OHM, 12'd0, 1'b1);
		push_item(ACT_START, RNG_CAP_LAST, 12'd0, 1'b0);
		push_item(ACT_CONVERT, RNG_RAW, 12'd1234, 1'b0);
		push_item(ACT_TICK, RNG_OHM, 12'd0, 1'b1);
		push_item(ACT_TICK, RNG_OHM, 12'd0, 1'b0);
		push_item(ACT_TICK, RNG_OHM, 12'd0, 1'b0);
		settle();

		for (k = 0; k < 6; k++) begin
			send_gap_pct = (k < 2) ? 25 : (k < 4) ? 53 : 0;
			recv_stall_pct = (k < 2) ? 53 : (k < 4) ? 25 : 0;
			write_mux(mux_plan[k]);
			random_chunk(90, 3);
			settle();
		end

		// a count long enough to clear the microfarad zero threshold
		push_item(ACT_START, RNG_CAP_LAST, 12'd0, 1'b0);
		repeat (LONG_CHARGE_TICKS) tick_high();
		push_item(ACT_TICK, RNG_OHM, 12'd0, 1'b0);
		push_item(ACT_CONVERT, RNG_REPEAT, 12'd0, 1'b0);
		settle();

		if (readings_due.size() != 0) flag_error("readings still outstanding at end of run");
		if (mismatches == 0) begin
			$display("PASS meter_range_converter_unit");
		end else begin
			$display("FAIL meter_range_converter_unit");
		end
		$finish;
	end

endmodule
